/* hdl/ssde_pkg.sv */
// ----------------------------------------------------------------------------
// ssde_pkg
// types and constants shared by the switch scan debouncer
// ----------------------------------------------------------------------------
package ssde_pkg;

  localparam int NumSwitchesDef = 16;
  localparam int TimeBitsDef    = 32;

  localparam int DebounceW = 16;
  localparam int SwCountW  = 5;
  localparam int ChannelW  = 4;
  localparam int IndexW    = 4;
  localparam int VelocityW = 7;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;

  localparam logic [DebounceW-1:0] DebounceRst = 16'd50;
  localparam logic [SwCountW-1:0]  SwCountRst  = 5'd16;
  localparam logic [ChannelW-1:0]  ChannelRst  = 4'd0;
  localparam logic [VelocityW-1:0] VelocityFull = 7'd127;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_SW_COUNT = 2'd1,
    CFG_CHANNEL  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CMD_TICK   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef struct packed {
    logic              cmd;
    logic [IndexW-1:0] switch_index;
    logic              level;
  } ssde_in_t;

  typedef struct packed {
    logic [IndexW-1:0]    note_index;
    logic                 is_on;
    logic [VelocityW-1:0] velocity;
    logic [ChannelW-1:0]  channel;
  } ssde_out_t;

endpackage

/* hdl/ssde_ram.sv */
// ----------------------------------------------------------------------------
// ssde_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module ssde_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/switch_scan_debounce_events_top.sv */
// ----------------------------------------------------------------------------
// switch_scan_debounce_events_top
// debounces scanned switches against a millisecond counter, emits note events
// ----------------------------------------------------------------------------
// Input transactions carry either a tick (advances the millisecond counter)
// or a sample (switch index and raw level). An accepted sample of a switch
// in use whose level differs from its stored level, more than debounce_ms
// after its last change, yields one note event on the output channel.
// Per-switch state (stored level, time of last change) lives in one ram
// with a registered read; a sample is read on acceptance, compared in the
// next cycle and, if it fires, written back as it leaves the compare stage,
// forwarding the last write so samples of a switch may follow back to back.
// Events are registered through the compare stage and output register.
// Throughput: one transaction per cycle unless the output stalls, set by
// the single ram ports. Ticks take effect at acceptance and produce nothing.
// Reset clears the counter, the registers to their defaults and the
// per-entry valid flags, so all switches read as low at time zero; no
// clearing pass is needed. When the receiver stalls, a held event stays in
// the output register while one more sample waits in the compare stage;
// input ready drops only when both are occupied. Configuration writes are
// plain register writes; the user must make them only while idle (unenforced).
// ----------------------------------------------------------------------------
module switch_scan_debounce_events_top
  import ssde_pkg::*;
#(
  parameter int NumSwitches = NumSwitchesDef,
  parameter int TimeBits    = TimeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ssde_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ssde_out_t           out_data_o
);

  localparam int AddrW  = (NumSwitches > 1) ? $clog2(NumSwitches) : 1;
  localparam int EntryW = TimeBits + 1;

  logic [DebounceW-1:0] debounce_q;
  logic [SwCountW-1:0]  sw_count_q;
  logic [ChannelW-1:0]  channel_q;

  logic [TimeBits-1:0] now_q, now_d;

  logic                s1_valid_q;
  logic [AddrW-1:0]    s1_addr_q;
  logic [IndexW-1:0]   s1_index_q;
  logic                s1_level_q;
  logic [TimeBits-1:0] s1_now_q;

  logic [NumSwitches-1:0] vld_q;

  logic                wr_vld_q;
  logic [AddrW-1:0]    wr_addr_q;
  logic [EntryW-1:0]   wr_data_q;

  logic      out_valid_q;
  ssde_out_t out_data_q;

  logic              in_acc;
  logic              in_range;
  logic [AddrW-1:0]  in_addr;
  logic              s1_adv;
  logic [EntryW-1:0] rdata;
  logic [EntryW-1:0] entry;
  logic [EntryW-1:0] wdata;
  logic              last_level;
  logic [TimeBits-1:0] last_time;
  logic [TimeBits-1:0] elapsed;
  logic              fire;
  logic              we;

  assign in_acc   = in_valid_i && in_ready_o;
  assign in_addr  = AddrW'(in_data_i.switch_index);
  assign in_range = ({1'b0, in_data_i.switch_index} < sw_count_q) &&
                    (int'(in_data_i.switch_index) < NumSwitches);
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;

  // tick counter
  always_comb begin
    now_d = now_q;
    if (in_acc && (in_data_i.cmd == CMD_TICK)) begin
      now_d = now_q + TimeBits'(1);
    end
  end

  ssde_ram #(
    .Width(EntryW),
    .Depth(NumSwitches)
  ) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(s1_addr_q),
    .wdata_i(wdata),
    .re_i   (in_acc),
    .raddr_i(in_addr),
    .rdata_o(rdata)
  );

  // forward the last write, unwritten entries read as zero
  always_comb begin
    if (wr_vld_q && (wr_addr_q == s1_addr_q)) begin
      entry = wr_data_q;
    end else if (vld_q[s1_addr_q]) begin
      entry = rdata;
    end else begin
      entry = '0;
    end
  end

  assign last_level = entry[EntryW-1];
  assign last_time  = entry[TimeBits-1:0];
  assign elapsed    = s1_now_q - last_time;
  assign fire       = s1_valid_q && (elapsed > TimeBits'(debounce_q)) &&
                      (last_level != s1_level_q);
  assign we         = fire && s1_adv;
  assign wdata      = {s1_level_q, s1_now_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= DebounceRst;
      sw_count_q  <= SwCountRst;
      channel_q   <= ChannelRst;
      now_q       <= '0;
      s1_valid_q  <= 1'b0;
      vld_q       <= '0;
      wr_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEBOUNCE: debounce_q <= cfg_wdata_i[DebounceW-1:0];
          CFG_SW_COUNT: sw_count_q <= cfg_wdata_i[SwCountW-1:0];
          CFG_CHANNEL:  channel_q  <= cfg_wdata_i[ChannelW-1:0];
          default: ;
        endcase
      end
      now_q <= now_d;
      if (in_ready_o) begin
        s1_valid_q <= in_acc && (in_data_i.cmd == CMD_SAMPLE) && in_range;
      end
      if (we) begin
        vld_q[s1_addr_q] <= 1'b1;
        wr_vld_q         <= 1'b1;
      end
      if (s1_adv) begin
        out_valid_q <= fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_addr_q  <= in_addr;
      s1_index_q <= in_data_i.switch_index;
      s1_level_q <= in_data_i.level;
      s1_now_q   <= now_q;
    end
    if (we) begin
      wr_addr_q <= s1_addr_q;
      wr_data_q <= wdata;
    end
    if (s1_adv && fire) begin
      out_data_q.note_index <= s1_index_q;
      out_data_q.is_on      <= !s1_level_q;
      out_data_q.velocity   <= VelocityFull;
      out_data_q.channel    <= channel_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* hdl/ssde_checker.sv */
// ----------------------------------------------------------------------------
// ssde_checker
// port level checks of the switch scan debouncer, bound to the top level
// ----------------------------------------------------------------------------
module ssde_checker
  import ssde_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input ssde_out_t out_data_o
);

  // held event stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  // velocity is always full scale
  a_velocity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.velocity == VelocityFull)
    else $error("event velocity not full scale");

  // input only stalls behind a blocked output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // an event needs a preceding accepted transaction, registered through the compare stage
  a_event_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("event without a preceding input transaction");

endmodule

bind switch_scan_debounce_events_top ssde_checker u_ssde_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
